>>> rtl/msis_pkg.sv
// shared constants, codes and control types for the multi-slot interval scheduler
package msis_pkg;

   // table and field sizes
   localparam int NUM_SLOTS   = 16;
   localparam int TIME_W      = 32;
   localparam int SLOT_W      = 4;
   localparam int DELTA_W     = 32;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 40;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

   // slot modes
   localparam logic MODE_FRAME    = 1'b0;
   localparam logic MODE_INTERVAL = 1'b1;

   // command codes carried on req_tuser
   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SUBSCRIBE = 2'd1,
      CMD_UPDATE    = 2'd2,
      CMD_REMOVE    = 2'd3
   } cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic             accept;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             eval;
      logic [IDX_W-1:0] eval_idx;
      logic             report;
      logic             flush;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic fire_rep;
      logic stall;
      logic hold_vld;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/multi_slot_interval_scheduler.sv
// top level of the multi-slot interval scheduler: controller plus slot datapath
//
//   channel   direction   payload
//   req       in          tuser: cmd; tdata: slot, sub_mode, period, main_thread_only, elapsed
//   rsp       out         tuser: to_main_queue; tdata: fired_slot, delta_time; tlast: last_fire
//
// subscribe, update and remove are accepted in idle; the block is ready again the next cycle.
// a tick passes the accept, a read of the first slot, the walk and a flush; the walk takes
// one slot per cycle through the single read port of the slot table while no stall holds it.
// a stalled result side holds the walk only when a second firing is waiting, and holds
// the flush until the output register is free.
// reset clears the valid bits at once; no clearing pass is needed.
module multi_slot_interval_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [69:38] elapsed, [37] main_thread_only, [36:5] period, [4] sub_mode, [3:0] slot
   input  logic [msis_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] cmd
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [35:4] delta_time, [3:0] fired_slot
   output logic [msis_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] to_main_queue
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   msis_pkg::ctl_type                ctl;
   msis_pkg::sts_type                sts;
   msis_pkg::cmd_type                req_cmd;
   logic [msis_pkg::SLOT_W-1:0]      fired_slot;
   logic [msis_pkg::DELTA_W-1:0]     delta_time;
   logic                             to_main_queue;

   assign req_cmd = msis_pkg::cmd_type'(req_tuser);

   msis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_cmd),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   msis_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (ctl),
      .req_cmd              (req_cmd),
      .req_slot             (req_tdata[3:0]),
      .req_sub_mode         (req_tdata[4]),
      .req_period           (req_tdata[36:5]),
      .req_main_thread_only (req_tdata[37]),
      .req_elapsed          (req_tdata[69:38]),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_fired_slot       (fired_slot),
      .rsp_delta_time       (delta_time),
      .rsp_to_main_queue    (to_main_queue),
      .rsp_last_fire        (rsp_tlast),
      .sts                  (sts)
   );

   // pack the result transaction
   assign rsp_tdata = {4'b0000, delta_time, fired_slot};
   assign rsp_tuser = to_main_queue;

endmodule

>>> rtl/msis_ctrl.sv
// controller: command acceptance and the slot walk sequencer for ticks
module msis_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  msis_pkg::cmd_type   req_cmd,
   output logic                req_tready,
   input  msis_pkg::sts_type   sts,
   output msis_pkg::ctl_type   ctl
);

   msis_pkg::state_type              state_ff, state_in;
   logic [msis_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [msis_pkg::CNT_W-1:0]       cnt_ff, cnt_in;

   // state, walk index and result count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msis_pkg::ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      req_tready   = 1'b0;
      ctl.accept   = 1'b0;
      ctl.rd_en    = 1'b0;
      ctl.rd_idx   = idx_ff + msis_pkg::IDX_W'(1);
      ctl.eval     = 1'b0;
      ctl.eval_idx = idx_ff;
      ctl.report   = (cnt_ff < msis_pkg::CNT_W'(msis_pkg::MAX_RESULTS));
      ctl.flush    = 1'b0;
      case (state_ff)
         msis_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.accept = 1'b1;
               if (req_cmd == msis_pkg::CMD_TICK) begin
                  state_in = msis_pkg::ST_LOOK;
                  cnt_in   = '0;
               end
            end
         end
         // read the first slot
         msis_pkg::ST_LOOK: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = '0;
            idx_in     = '0;
            state_in   = msis_pkg::ST_EVAL;
         end
         // evaluate one slot while the next one is read
         msis_pkg::ST_EVAL: begin
            ctl.eval = 1'b1;
            if (!sts.stall) begin
               if (sts.fire_rep) begin
                  cnt_in = cnt_ff + msis_pkg::CNT_W'(1);
               end
               if (idx_ff == msis_pkg::IDX_LAST) begin
                  state_in = msis_pkg::ST_FLUSH;
               end else begin
                  ctl.rd_en = 1'b1;
                  idx_in    = idx_ff + msis_pkg::IDX_W'(1);
               end
            end
         end
         // release the held result as the last one of the tick
         msis_pkg::ST_FLUSH: begin
            if (!sts.hold_vld) begin
               state_in = msis_pkg::ST_IDLE;
            end else if (sts.out_free) begin
               ctl.flush = 1'b1;
               state_in  = msis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msis_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/msis_dp.sv
// datapath: slot table, accumulator arithmetic, held result and output register
module msis_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  msis_pkg::ctl_type                  ctl,
   input  msis_pkg::cmd_type                  req_cmd,
   input  logic [msis_pkg::SLOT_W-1:0]        req_slot,
   input  logic                               req_sub_mode,
   input  logic [31:0]                        req_period,
   input  logic                               req_main_thread_only,
   input  logic [31:0]                        req_elapsed,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [msis_pkg::SLOT_W-1:0]        rsp_fired_slot,
   output logic [msis_pkg::DELTA_W-1:0]       rsp_delta_time,
   output logic                               rsp_to_main_queue,
   output logic                               rsp_last_fire,
   output msis_pkg::sts_type                  sts
);

   localparam int TW = msis_pkg::TIME_W;
   localparam int IW = msis_pkg::IDX_W;

   // slot table: valid bits in flops, the rest in memories
   logic [msis_pkg::NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [TW:0]                    mp_mem   [msis_pkg::NUM_SLOTS];
   logic                           main_mem [msis_pkg::NUM_SLOTS];
   logic [TW-1:0]                  acc_mem  [msis_pkg::NUM_SLOTS];

   logic          mode_rd_ff;
   logic [TW-1:0] period_rd_ff;
   logic          main_rd_ff;
   logic [TW-1:0] acc_rd_ff;
   logic [TW-1:0] elapsed_ff;

   logic                            hold_vld_ff, hold_vld_in;
   logic [msis_pkg::SLOT_W-1:0]     hold_slot_ff;
   logic [msis_pkg::DELTA_W-1:0]    hold_delta_ff;
   logic                            hold_main_ff;

   logic                            out_vld_ff, out_vld_in;
   logic [msis_pkg::SLOT_W-1:0]     out_slot_ff;
   logic [msis_pkg::DELTA_W-1:0]    out_delta_ff;
   logic                            out_main_ff;
   logic                            out_last_ff;

   logic [IW-1:0] slot_idx;
   logic          in_range;
   logic          sub_we, upd_we, rem_we;
   logic          acc_we;
   logic [IW-1:0] acc_waddr;
   logic [TW-1:0] acc_wdata;

   logic [TW:0]   sum_ext;
   logic [TW+1:0] diff_ext;
   logic          sat, ge;
   logic [TW-1:0] new_acc;
   logic [TW-1:0] delta;
   logic          fire, fire_rep, stall, out_free, step, push_hold, move_out;

   // decode of table commands
   assign slot_idx = IW'(req_slot);
   assign in_range = (32'(req_slot) < 32'(msis_pkg::NUM_SLOTS));
   assign sub_we   = ctl.accept && (req_cmd == msis_pkg::CMD_SUBSCRIBE) && in_range;
   assign upd_we   = ctl.accept && (req_cmd == msis_pkg::CMD_UPDATE) && in_range
                     && valid_ff[slot_idx];
   assign rem_we   = ctl.accept && (req_cmd == msis_pkg::CMD_REMOVE) && in_range;

   // valid bits
   always_comb begin
      valid_in = valid_ff;
      if (sub_we) begin
         valid_in[slot_idx] = 1'b1;
      end else if (rem_we) begin
         valid_in[slot_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // elapsed time of the current tick
   always_ff @(posedge clock) begin
      if (ctl.accept && (req_cmd == msis_pkg::CMD_TICK)) begin
         elapsed_ff <= TW'(req_elapsed);
      end
   end

   // mode and period memory
   always_ff @(posedge clock) begin
      if (sub_we || upd_we) begin
         mp_mem[slot_idx] <= {req_sub_mode, TW'(req_period)};
      end
      if (ctl.rd_en) begin
         {mode_rd_ff, period_rd_ff} <= mp_mem[ctl.rd_idx];
      end
   end

   // main-thread flag memory
   always_ff @(posedge clock) begin
      if (sub_we) begin
         main_mem[slot_idx] <= req_main_thread_only;
      end
      if (ctl.rd_en) begin
         main_rd_ff <= main_mem[ctl.rd_idx];
      end
   end

   // accumulator memory, cleared on subscribe, rewritten during the walk
   assign acc_waddr = ctl.eval ? ctl.eval_idx : slot_idx;
   assign acc_wdata = ctl.eval ? new_acc : '0;

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      if (ctl.rd_en) begin
         acc_rd_ff <= acc_mem[ctl.rd_idx];
      end
   end

   // saturating accumulate and period compare
   assign sum_ext  = {1'b0, acc_rd_ff} + {1'b0, elapsed_ff};
   assign diff_ext = {2'b00, acc_rd_ff} + {2'b00, elapsed_ff} - {2'b00, period_rd_ff};
   assign sat      = sum_ext[TW];
   assign ge       = sat || !diff_ext[TW+1];

   always_comb begin
      if (!ge) begin
         new_acc = sum_ext[TW-1:0];
      end else if (sat) begin
         new_acc = '1 - period_rd_ff;
      end else begin
         new_acc = diff_ext[TW-1:0];
      end
   end

   // firing decision for the evaluated slot
   assign fire  = valid_ff[ctl.eval_idx] && ((mode_rd_ff == msis_pkg::MODE_FRAME) || ge);
   assign delta = (mode_rd_ff == msis_pkg::MODE_FRAME) ? elapsed_ff : period_rd_ff;

   assign out_free  = !out_vld_ff || rsp_tready;
   assign fire_rep  = ctl.eval && fire && ctl.report;
   assign stall     = fire_rep && hold_vld_ff && !out_free;
   assign step      = ctl.eval && !stall;
   assign push_hold = step && fire_rep;
   assign move_out  = (push_hold && hold_vld_ff) || ctl.flush;
   assign acc_we    = sub_we || (step && valid_ff[ctl.eval_idx]
                                 && (mode_rd_ff == msis_pkg::MODE_INTERVAL));

   // held result: waits until it is known whether it ends the tick
   assign hold_vld_in = push_hold ? 1'b1 : (ctl.flush ? 1'b0 : hold_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_hold) begin
         hold_slot_ff  <= msis_pkg::SLOT_W'(ctl.eval_idx);
         hold_delta_ff <= msis_pkg::DELTA_W'(delta);
         hold_main_ff  <= main_rd_ff;
      end
   end

   // output register
   assign out_vld_in = move_out ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         out_slot_ff  <= hold_slot_ff;
         out_delta_ff <= hold_delta_ff;
         out_main_ff  <= hold_main_ff;
         out_last_ff  <= ctl.flush;
      end
   end

   assign rsp_tvalid        = out_vld_ff;
   assign rsp_fired_slot    = out_slot_ff;
   assign rsp_delta_time    = out_delta_ff;
   assign rsp_to_main_queue = out_main_ff;
   assign rsp_last_fire     = out_last_ff;

   assign sts.fire_rep = fire_rep;
   assign sts.stall    = stall;
   assign sts.hold_vld = hold_vld_ff;
   assign sts.out_free = out_free;

endmodule

>>> rtl/msis_checker.sv
// port-level checks for the multi-slot interval scheduler and their binding
module msis_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic                             rsp_tlast
);

   logic req_acc;
   logic req_tick;

   assign req_acc  = req_tvalid && req_tready;
   assign req_tick = (req_tuser == 2'(msis_pkg::CMD_TICK));

   // a pending result transaction is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a tick occupies the block for at least the following cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tick |=> !req_tready)
      else $error("ready right after a tick transaction");

   // after a table command the block is ready again in the following cycle
   a_cmd_quick: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_tick |=> req_tready)
      else $error("not ready after a table command");

   // once idle, only the closing result of a tick can still be waiting
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("non-final result pending while idle");

endmodule

bind multi_slot_interval_scheduler msis_checker u_msis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
